>>> hw/rtl/acesc_pkg.sv
// Shared types and constants for the ANSI-C escape decoder.
package acesc_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TEXT,
        PH_ESC,
        PH_CTRL,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        BASE_NONE,
        BASE_OCT,
        BASE_HEX
    } base_t;

    typedef struct packed {
        phase_t     phase;
        base_t      base;
        logic [3:0] left;
        logic [7:0] accum;
    } dec_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } result_t;

    typedef struct packed {
        dec_state_t nxt;
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_out_t;

    localparam dec_state_t STATE_RESET = '{PH_IDLE, BASE_NONE, 4'd0, 8'd0};

endpackage

>>> hw/rtl/acesc_step.sv
// Next-state and result logic for one input byte of the escape decoder.
module acesc_step
    import acesc_pkg::*;
(
    input  dec_state_t cur,
    input  logic [7:0] in_byte,
    output step_out_t  res
);

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_QM    = 8'h3F;
    localparam logic [7:0] CTRL_OFS = 8'h60;

    localparam result_t NO_RESULT = '{8'd0, 1'b0, 1'b0};

    typedef struct packed {
        phase_t     phase;
        logic       emit;
        result_t    r;
    } text_t;

    // plain-text handling of a non-NUL byte
    function automatic text_t text_byte(input logic [7:0] b);
        text_t t;
        t.phase = PH_TEXT;
        t.emit  = 1'b1;
        t.r     = '{b, 1'b0, 1'b0};
        if (b == CH_BSL)
        begin
            t.phase = PH_ESC;
            t.emit  = 1'b0;
        end
        else if (b == CH_QUOTE)
        begin
            t.phase = PH_IDLE;
            t.r.last = 1'b1;
        end
        return t;
    endfunction

    logic       dig_ok;
    logic [3:0] dig_val;
    logic [7:0] acc_new;
    text_t      txt;

    always_comb
    begin
        dig_ok  = 1'b0;
        dig_val = in_byte[3:0];
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            dig_ok = (cur.base == BASE_HEX) || (cur.base == BASE_OCT && in_byte <= 8'h37);
        end
        else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46))
        begin
            dig_ok  = (cur.base == BASE_HEX);
            dig_val = in_byte[3:0] + 4'd9;
        end
        if (cur.base == BASE_OCT)
            acc_new = {cur.accum[4:0], dig_val[2:0]};
        else
            acc_new = {cur.accum[3:0], dig_val};
    end

    assign txt = text_byte(in_byte);

    always_comb
    begin
        res.nxt   = cur;
        res.count = 2'd0;
        res.r0    = NO_RESULT;
        res.r1    = NO_RESULT;
        if (cur.phase == PH_IDLE)
        begin
            res.nxt.phase = PH_TEXT;
            res.count     = 2'd1;
            res.r0        = '{in_byte, 1'b0, 1'b0};
        end
        else if (in_byte == 8'd0)
        begin
            res.nxt   = STATE_RESET;
            res.count = 2'd1;
            res.r0    = '{8'd0, 1'b0, 1'b1};
        end
        else
        begin
            unique case (cur.phase)
                PH_ESC:
                begin
                    res.nxt.phase = PH_TEXT;
                    res.count     = 2'd1;
                    res.r0        = '{8'd0, 1'b0, 1'b0};
                    unique case (in_byte)
                        8'h61:    res.r0.data = 8'h07;   // a
                        8'h62:    res.r0.data = 8'h08;   // b
                        8'h65:    res.r0.data = 8'h1B;   // e
                        8'h66:    res.r0.data = 8'h0C;   // f
                        8'h6E:    res.r0.data = 8'h0A;   // n
                        8'h72:    res.r0.data = 8'h0D;   // r
                        8'h74:    res.r0.data = 8'h09;   // t
                        8'h76:    res.r0.data = 8'h0B;   // v
                        CH_BSL:   res.r0.data = CH_BSL;
                        CH_DQ:    res.r0.data = CH_DQ;
                        CH_QM:    res.r0.data = CH_QM;
                        CH_QUOTE: res.r0.data = CH_QUOTE;
                        8'h63:                           // c
                        begin
                            res.nxt.phase = PH_CTRL;
                            res.count     = 2'd0;
                        end
                        8'h30, 8'h78, 8'h75, 8'h55:      // 0 x u U
                        begin
                            res.nxt.phase = PH_DIGITS;
                            res.nxt.base  = (in_byte == 8'h30) ? BASE_OCT : BASE_HEX;
                            res.nxt.left  = (in_byte == 8'h55) ? 4'd8 :
                                            (in_byte == 8'h75) ? 4'd4 : 4'd2;
                            res.nxt.accum = 8'd0;
                            res.count     = 2'd0;
                        end
                        default:
                        begin
                            res.count = 2'd2;
                            res.r0    = '{CH_BSL, 1'b0, 1'b0};
                            res.r1    = '{in_byte, 1'b0, 1'b0};
                        end
                    endcase
                end
                PH_CTRL:
                begin
                    res.nxt.phase = PH_TEXT;
                    res.count     = 2'd1;
                    res.r0        = '{in_byte - CTRL_OFS, 1'b0, 1'b0};
                end
                PH_DIGITS:
                begin
                    if (dig_ok && cur.left != 4'd0)
                    begin
                        res.nxt.accum = acc_new;
                        res.nxt.left  = cur.left - 4'd1;
                        if (cur.left == 4'd1)
                        begin
                            res.nxt.phase = PH_TEXT;
                            res.nxt.base  = BASE_NONE;
                            res.nxt.accum = 8'd0;
                            res.count     = 2'd1;
                            res.r0        = '{acc_new, 1'b0, 1'b0};
                        end
                    end
                    else
                    begin
                        res.nxt.base  = BASE_NONE;
                        res.nxt.left  = 4'd0;
                        res.nxt.accum = 8'd0;
                        res.nxt.phase = txt.phase;
                        res.r0        = '{cur.accum, 1'b0, 1'b0};
                        res.r1        = txt.r;
                        res.count     = txt.emit ? 2'd2 : 2'd1;
                    end
                end
                default:
                begin
                    res.nxt.base  = BASE_NONE;
                    res.nxt.left  = 4'd0;
                    res.nxt.accum = 8'd0;
                    res.nxt.phase = txt.phase;
                    res.r0        = txt.r;
                    res.count     = txt.emit ? 2'd1 : 2'd0;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/ansi_c_escape_decoder.sv
// Top level of the ANSI-C quoted string escape decoder.
// A byte's results are registered into the result queue when the byte is accepted.
// Throughput: one byte per cycle while in_stall is low; a byte may queue up to two results.
// A four-entry result queue decouples input from output; input stalls above two entries.
// Reset (rst_n low, asynchronous) returns to awaiting the opening byte and empties the queue.
module ansi_c_escape_decoder
    import acesc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       is_last,
    output logic       bad_input
);

    dec_state_t         state_reg;
    step_out_t          step;
    result_t            fifo_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg;
    logic [Q_PTR_W-1:0] rptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic [Q_CNT_W-1:0] cnt_next;
    logic               push;
    logic               pop;
    logic [1:0]         push_cnt;

    acesc_step u_step (
        .cur     (state_reg),
        .in_byte (in_byte),
        .res     (step)
    );

    assign in_stall  = cnt_reg > Q_CNT_W'(Q_DEPTH - 2);
    assign push      = in_valid && !in_stall;
    assign out_valid = cnt_reg != '0;
    assign pop       = out_valid && !out_stall;
    assign push_cnt  = push ? step.count : 2'd0;
    assign cnt_next  = cnt_reg + Q_CNT_W'(push_cnt) - Q_CNT_W'(pop);

    assign out_byte  = fifo_reg[rptr_reg].data;
    assign is_last   = fifo_reg[rptr_reg].last;
    assign bad_input = fifo_reg[rptr_reg].bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                state_reg <= step.nxt;
                wptr_reg  <= wptr_reg + Q_PTR_W'(step.count);
            end
            if (pop)
                rptr_reg <= rptr_reg + Q_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && step.count != 2'd0)
            fifo_reg[wptr_reg] <= step.r0;
        if (push && step.count == 2'd2)
            fifo_reg[wptr_reg + Q_PTR_W'(1)] <= step.r1;
    end

endmodule

>>> hw/rtl/acesc_checker.sv
// Port-level assertions for the escape decoder, bound to the top level.
module acesc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       is_last,
    input logic       bad_input
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(is_last)
            && $stable(bad_input))
        else $error("stalled output item changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte))
        else $error("stalled input item changed");

    a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_input |-> out_byte == 8'h00 && !is_last)
        else $error("error item carries data or last");

    a_last_quote: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_last |-> out_byte == 8'h27 && !bad_input)
        else $error("last item is not a closing quote");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n ##1 !rst_n |-> !out_valid && !in_stall)
        else $error("queue not empty during reset");

endmodule

bind ansi_c_escape_decoder acesc_checker u_acesc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .is_last   (is_last),
    .bad_input (bad_input)
);

>>> verif/testbench.sv
// Testbench for the ANSI-C escape decoder: drives quoted strings, predicts and checks each item.
module testbench;
    import acesc_pkg::*;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] QUOTE = 8'h27;
    localparam logic [7:0] DQUOTE = 8'h22;
    localparam logic [7:0] NUL = 8'h00;
    localparam logic [7:0] CTRL_OFFSET = 8'h60;
    localparam int SOURCE_ITEMS = 550;
    localparam int MAX_WAIT = 11;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] in_byte = 8'h00;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] out_byte;
    logic is_last;
    logic bad_input;

    logic [7:0] source_bytes[$];
    result_t pending_decoded[$];

    phase_t dec_phase = PH_IDLE;
    base_t dec_base = BASE_NONE;
    logic [3:0] dec_left = 4'd0;
    logic [7:0] dec_accum = 8'd0;

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    logic in_calm = 1'b0;
    logic out_calm = 1'b0;
    int in_gap = 0;
    int out_hold = 0;
    int mismatches = 0;

    ansi_c_escape_decoder uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_byte(in_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .is_last(is_last),
        .bad_input(bad_input)
    );

    always #5 clk = ~clk;

    function automatic void queue_decoded(logic [7:0] data, logic last, logic bad);
        result_t r;
        r.data = data;
        r.last = last;
        r.bad = bad;
        pending_decoded.push_back(r);
    endfunction

    function automatic void clear_run();
        dec_base = BASE_NONE;
        dec_left = 4'd0;
        dec_accum = 8'd0;
    endfunction

    function automatic void open_run(base_t base, logic [3:0] count);
        dec_phase = PH_DIGITS;
        dec_base = base;
        dec_left = count;
        dec_accum = 8'd0;
    endfunction

    function automatic void decode_text(logic [7:0] b);
        if (b == BACKSLASH)
        begin
            dec_phase = PH_ESC;
        end
        else if (b == QUOTE)
        begin
            queue_decoded(b, 1'b1, 1'b0);
            dec_phase = PH_IDLE;
            clear_run();
        end
        else
        begin
            dec_phase = PH_TEXT;
            queue_decoded(b, 1'b0, 1'b0);
        end
    endfunction

    function automatic int digit_value(logic [7:0] b);
        int d = -1;
        if (b >= "0" && b <= "9")
            d = b - "0";
        else if (b >= "a" && b <= "f")
            d = b - "a" + 10;
        else if (b >= "A" && b <= "F")
            d = b - "A" + 10;
        if (dec_base == BASE_NONE || (dec_base == BASE_OCT && d >= 8))
            d = -1;
        return d;
    endfunction

    function automatic void decode_escape(logic [7:0] b);
        dec_phase = PH_TEXT;
        case (b)
            "a": queue_decoded(8'h07, 1'b0, 1'b0);
            "b": queue_decoded(8'h08, 1'b0, 1'b0);
            "e": queue_decoded(8'h1B, 1'b0, 1'b0);
            "f": queue_decoded(8'h0C, 1'b0, 1'b0);
            "n": queue_decoded(8'h0A, 1'b0, 1'b0);
            "r": queue_decoded(8'h0D, 1'b0, 1'b0);
            "t": queue_decoded(8'h09, 1'b0, 1'b0);
            "v": queue_decoded(8'h0B, 1'b0, 1'b0);
            BACKSLASH, DQUOTE, "?", QUOTE: queue_decoded(b, 1'b0, 1'b0);
            "c": dec_phase = PH_CTRL;
            "0": open_run(BASE_OCT, 4'd2);
            "x": open_run(BASE_HEX, 4'd2);
            "u": open_run(BASE_HEX, 4'd4);
            "U": open_run(BASE_HEX, 4'd8);
            default:
            begin
                queue_decoded(BACKSLASH, 1'b0, 1'b0);
                queue_decoded(b, 1'b0, 1'b0);
            end
        endcase
    endfunction

    function automatic void decode_source_byte(logic [7:0] b);
        int d;
        if (dec_phase == PH_IDLE)
        begin
            dec_phase = PH_TEXT;
            queue_decoded(b, 1'b0, 1'b0);
        end
        else if (b == NUL)
        begin
            dec_phase = PH_IDLE;
            clear_run();
            queue_decoded(NUL, 1'b0, 1'b1);
        end
        else
        begin
            case (dec_phase)
                PH_ESC: decode_escape(b);
                PH_CTRL:
                begin
                    dec_phase = PH_TEXT;
                    queue_decoded(b - CTRL_OFFSET, 1'b0, 1'b0);
                end
                PH_DIGITS:
                begin
                    d = digit_value(b);
                    if (d >= 0 && dec_left != 4'd0)
                    begin
                        if (dec_base == BASE_OCT)
                            dec_accum = {dec_accum[4:0], 3'b000} + 8'(d);
                        else
                            dec_accum = {dec_accum[3:0], 4'b0000} + 8'(d);
                        dec_left = dec_left - 4'd1;
                        if (dec_left == 4'd0)
                        begin
                            queue_decoded(dec_accum, 1'b0, 1'b0);
                            dec_phase = PH_TEXT;
                            clear_run();
                        end
                    end
                    else
                    begin
                        queue_decoded(dec_accum, 1'b0, 1'b0);
                        clear_run();
                        decode_text(b);
                    end
                end
                default:
                begin
                    clear_run();
                    decode_text(b);
                end
            endcase
        end
    endfunction

    function automatic void send(logic [7:0] b);
        source_bytes.push_back(b);
    endfunction

    function automatic logic is_escape_letter(logic [7:0] b);
        case (b)
            "a", "b", "e", "f", "n", "r", "t", "v", BACKSLASH, DQUOTE, "?", QUOTE,
            "c", "0", "x", "u", "U": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] simple_escape();
        case ($urandom_range(0, 11))
            0: return "a";
            1: return "b";
            2: return "e";
            3: return "f";
            4: return "n";
            5: return "r";
            6: return "t";
            7: return "v";
            8: return BACKSLASH;
            9: return DQUOTE;
            10: return "?";
            default: return QUOTE;
        endcase
    endfunction

    function automatic logic [7:0] hex_digit();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10)
            return 8'("0" + k);
        else if (k < 16)
            return 8'("a" + k - 10);
        return 8'("A" + k - 16);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == BACKSLASH || b == QUOTE);
        return b;
    endfunction

    task automatic queue_string();
        int tokens;
        logic [7:0] b;
        send($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255)) : QUOTE);
        tokens = $urandom_range(0, 12);
        repeat (tokens)
        begin
            case ($urandom_range(0, 15))
                5, 6:
                begin
                    send(BACKSLASH);
                    send(simple_escape());
                end
                7:
                begin
                    send(BACKSLASH);
                    send("c");
                    send(8'($urandom_range(1, 255)));
                end
                8:
                begin
                    send(BACKSLASH);
                    send("0");
                    repeat ($urandom_range(0, 3)) send(8'("0" + $urandom_range(0, 7)));
                end
                9:
                begin
                    send(BACKSLASH);
                    send("x");
                    repeat ($urandom_range(0, 3)) send(hex_digit());
                end
                10:
                begin
                    send(BACKSLASH);
                    send("u");
                    repeat ($urandom_range(0, 5)) send(hex_digit());
                end
                11:
                begin
                    send(BACKSLASH);
                    send("U");
                    repeat ($urandom_range(0, 9)) send(hex_digit());
                end
                12:
                begin
                    do
                        b = 8'($urandom_range(1, 255));
                    while (is_escape_letter(b));
                    send(BACKSLASH);
                    send(b);
                end
                13: send(8'($urandom_range(0, 255)));
                default: send(plain_byte());
            endcase
        end
        send($urandom_range(0, 11) == 0 ? NUL : QUOTE);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (source_bytes.size() != 0)
            begin
                in_valid <= 1'b1;
                in_byte <= source_bytes.pop_front();
                in_gap <= in_calm ? 0 : $urandom_range(0, MAX_WAIT);
                if ($urandom_range(0, 39) == 0)
                    in_calm <= !in_calm;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : stall_driver
        int hold;
        hold = out_hold;
        if (out_taken)
        begin
            hold = out_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 39) == 0)
                out_calm <= !out_calm;
        end
        else if (hold == 0 && !out_calm && $urandom_range(0, 15) == 0)
        begin
            hold = $urandom_range(1, MAX_WAIT);
        end
        out_stall <= (hold > 0);
        out_hold <= (hold > 0) ? hold - 1 : 0;
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        in_taken <= in_valid && !in_stall;
        out_taken <= out_valid && !out_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                decode_source_byte(in_byte);
            if (out_valid && !out_stall)
            begin
                if (pending_decoded.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected item: byte %h last %b bad %b",
                                 out_byte, is_last, bad_input);
                end
                else
                begin
                    want = pending_decoded.pop_front();
                    if (out_byte !== want.data || is_last !== want.last ||
                        bad_input !== want.bad)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("item mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     want.data, want.last, want.bad,
                                     out_byte, is_last, bad_input);
                    end
                end
            end
        end
    end

    initial
    begin
        // NUL as opening byte, then 0xFF as text
        send(NUL);
        send(8'hFF);
        send(BACKSLASH);
        send("q");
        send(BACKSLASH);
        send("c");
        send(BACKSLASH);
        send(BACKSLASH);
        send("0");
        send("7");
        send("7");
        // empty hex run ended by a non-digit
        send(BACKSLASH);
        send("x");
        send("g");
        // unicode run cut short by the closing quote
        send(BACKSLASH);
        send("u");
        send("1");
        send(QUOTE);
        // NUL right after a backslash
        send(QUOTE);
        send(BACKSLASH);
        send(NUL);
        while (source_bytes.size() < SOURCE_ITEMS)
            queue_string();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (source_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_decoded.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/acesc_pkg.sv
hw/rtl/acesc_step.sv
hw/rtl/ansi_c_escape_decoder.sv
hw/rtl/acesc_checker.sv
verif/testbench.sv
